/* hw/rtl/radio_link_pairing_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the radio link pairing controller
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIO_LINK_PAIRING_CONTROLLER_ASSERT_SVH
`define RADIO_LINK_PAIRING_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define RLPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpc: same-cycle check failed");

// Next-cycle implication.
`define RLPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpc: next-cycle check failed");

`endif

/* hw/rtl/rlpc_pkg.sv */
// ----------------------------------------------------------------------------
// rlpc_pkg
// Types and constants of the radio link pairing controller.
// ----------------------------------------------------------------------------
package rlpc_pkg;

    // Handshake states.
    typedef enum logic [1:0] {
        ST_PAIRING = 2'd0,
        ST_CONFIG  = 2'd1,
        ST_TESTING = 2'd2,
        ST_NORMAL  = 2'd3
    } hs_state_t;

    // Status of the last transmit request.
    typedef enum logic [1:0] {
        TX_UNKNOWN = 2'd0,
        TX_PENDING = 2'd1,
        TX_OK      = 2'd2,
        TX_FAIL    = 2'd3
    } tx_status_t;

    // Input item kinds.
    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_POLL      = 2'd1,
        FUNC_TX_RESULT = 2'd2,
        FUNC_RX_PACKET = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NOP_CODE      = 3'd0;
    localparam logic [2:0] CFG_CONF_CODE     = 3'd1;
    localparam logic [2:0] CFG_TEST_CODE     = 3'd2;
    localparam logic [2:0] CFG_WORK_CHANNEL  = 3'd3;
    localparam logic [2:0] CFG_RX_WAIT_TICKS = 3'd4;
    localparam logic [2:0] CFG_LINK_TICKS    = 3'd5;

    // Reset values.
    localparam logic [7:0]  NOP_CODE_RST      = 8'd0;
    localparam logic [7:0]  CONF_CODE_RST     = 8'd1;
    localparam logic [7:0]  TEST_CODE_RST     = 8'd2;
    localparam logic [6:0]  WORK_CHANNEL_RST  = 7'd70;
    localparam logic [7:0]  RX_WAIT_TICKS_RST = 8'd100;
    localparam logic [7:0]  LINK_TICKS_RST    = 8'd50;
    localparam logic [7:0]  TICK_LIMIT_RST    = 8'd100;
    localparam logic [15:0] RAND_SEED_RST     = 16'hAA55;

    localparam int RAND_DEPTH = 8;

    // Random generator table after reset.
    localparam logic [15:0] RAND_TABLE_RST [RAND_DEPTH] = '{
        16'h2312, 16'h6745, 16'hAB89, 16'hEFCD,
        16'hE2F1, 16'hC4D3, 16'hA6B5, 16'h8897
    };

    // One result item.
    typedef struct packed {
        hs_state_t  link_state;
        logic       rx_mode;
        logic       send_valid;
        logic [7:0] send_code;
        logic       retune;
        logic [6:0] channel;
        logic       deliver_valid;
        logic [7:0] deliver_cmd;
        logic [4:0] deliver_len;
        logic       paired;
    } result_t;

endpackage

/* hw/rtl/radio_link_pairing_controller.sv */
// A result is registered into the result buffer when its input transaction is accepted.
// Throughput: one input transaction per cycle; all decisions are a single pass of
// logic from the input ports into a two-entry result buffer (output plus skid).
// Input ready drops only while both result entries are occupied.
// Reset (rst_n low, asynchronous) returns the handshake to pairing as transmitter,
// reloads the configuration defaults and the random seed and table, and empties the buffer.
// ----------------------------------------------------------------------------
// radio_link_pairing_controller
// Two-node radio pairing handshake with role swapping and random timeouts.
// ----------------------------------------------------------------------------
`include "radio_link_pairing_controller_assert.svh"

module radio_link_pairing_controller
(
    input  logic       clk,
    input  logic       rst_n,

    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,

    // Input item channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic       tx_ok,
    input  logic [7:0] rx_cmd,
    input  logic [5:0] rx_len,

    // Result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] link_state,
    output logic       rx_mode,
    output logic       send_valid,
    output logic [7:0] send_code,
    output logic       retune,
    output logic [6:0] channel,
    output logic       deliver_valid,
    output logic [7:0] deliver_cmd,
    output logic [4:0] deliver_len,
    output logic       paired
);

    // Configuration registers
    logic [7:0] nop_code_reg;
    logic [7:0] conf_code_reg;
    logic [7:0] test_code_reg;
    logic [6:0] work_channel_reg;
    logic [7:0] rx_wait_ticks_reg;
    logic [7:0] link_ticks_reg;

    // Handshake state
    rlpc_pkg::hs_state_t  hs_state_reg, hs_state_next;
    rlpc_pkg::tx_status_t tx_status_reg, tx_status_next;
    logic                 role_rx_reg, role_rx_next;
    logic                 linked_reg, linked_next;
    logic [7:0]           tick_count_reg, tick_count_next;
    logic [7:0]           tick_limit_reg, tick_limit_next;
    logic                 expired_reg, expired_next;
    logic [6:0]           cur_channel_reg, cur_channel_next;
    logic [15:0]          rand_seed_reg, rand_seed_next;
    logic [15:0]          rand_table_reg [rlpc_pkg::RAND_DEPTH];
    logic                 draw_en;

    // Result buffer
    logic                 head_valid_reg;
    logic                 skid_valid_reg;
    rlpc_pkg::result_t    head_reg;
    rlpc_pkg::result_t    skid_reg;
    rlpc_pkg::result_t    result;

    logic                 push;
    logic                 pop;
    rlpc_pkg::func_t      func_code;
    logic                 rx_live;
    logic                 is_nop;
    logic                 is_conf;
    logic                 is_test;
    logic [7:0]           tick_inc;
    logic [2:0]           rand_k;
    logic [15:0]          rand_word;
    logic [5:0]           len_m1;

    logic                 send_valid_c;
    logic [7:0]           send_code_c;
    logic                 retune_c;
    logic                 deliver_valid_c;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = head_valid_reg && out_ready;

    // Decoded input fields.
    assign func_code = rlpc_pkg::func_t'(func);
    assign rx_live   = (rx_len != 6'd0);
    assign is_nop    = (rx_cmd == nop_code_reg);
    assign is_conf   = !is_nop && (rx_cmd == conf_code_reg);
    assign is_test   = !is_nop && !is_conf && (rx_cmd == test_code_reg);
    assign tick_inc  = tick_count_reg + 8'd1;
    assign len_m1    = rx_len - 6'd1;

    // Random draw: one table word picked by the seed, summed with the seed.
    assign rand_k    = rand_seed_reg[3:1];
    assign rand_word = rand_table_reg[rand_k] + rand_seed_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nop_code_reg      <= rlpc_pkg::NOP_CODE_RST;
            conf_code_reg     <= rlpc_pkg::CONF_CODE_RST;
            test_code_reg     <= rlpc_pkg::TEST_CODE_RST;
            work_channel_reg  <= rlpc_pkg::WORK_CHANNEL_RST;
            rx_wait_ticks_reg <= rlpc_pkg::RX_WAIT_TICKS_RST;
            link_ticks_reg    <= rlpc_pkg::LINK_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rlpc_pkg::CFG_NOP_CODE:      nop_code_reg      <= cfg_data;
                rlpc_pkg::CFG_CONF_CODE:     conf_code_reg     <= cfg_data;
                rlpc_pkg::CFG_TEST_CODE:     test_code_reg     <= cfg_data;
                rlpc_pkg::CFG_WORK_CHANNEL:  work_channel_reg  <= cfg_data[6:0];
                rlpc_pkg::CFG_RX_WAIT_TICKS: rx_wait_ticks_reg <= cfg_data;
                rlpc_pkg::CFG_LINK_TICKS:    link_ticks_reg    <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Next state of the handshake, timer, role and random generator.
    always_comb
    begin
        hs_state_next    = hs_state_reg;
        tx_status_next   = tx_status_reg;
        role_rx_next     = role_rx_reg;
        linked_next      = linked_reg;
        tick_count_next  = tick_count_reg;
        tick_limit_next  = tick_limit_reg;
        expired_next     = expired_reg;
        cur_channel_next = cur_channel_reg;
        rand_seed_next   = rand_seed_reg;
        draw_en          = 1'b0;

        unique case (func_code)
            rlpc_pkg::FUNC_TICK:
            begin
                if (tick_inc == tick_limit_reg)
                begin
                    tick_count_next = 8'd0;
                    expired_next    = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            rlpc_pkg::FUNC_TX_RESULT:
            begin
                tx_status_next = tx_ok ? rlpc_pkg::TX_OK : rlpc_pkg::TX_FAIL;
            end
            rlpc_pkg::FUNC_RX_PACKET:
            begin
                if (rx_live)
                begin
                    priority if (is_nop)
                    begin
                        if (hs_state_reg == rlpc_pkg::ST_PAIRING)
                        begin
                            if (role_rx_reg)
                            begin
                                hs_state_next   = rlpc_pkg::ST_CONFIG;
                                tick_limit_next = rx_wait_ticks_reg;
                                tick_count_next = 8'd0;
                            end
                        end
                        else
                        begin
                            tick_count_next = 8'd0;
                        end
                    end
                    else if (is_conf)
                    begin
                        if (hs_state_reg == rlpc_pkg::ST_CONFIG && role_rx_reg)
                        begin
                            cur_channel_next = work_channel_reg;
                            hs_state_next    = rlpc_pkg::ST_TESTING;
                            tick_limit_next  = rx_wait_ticks_reg;
                            tick_count_next  = 8'd0;
                        end
                    end
                    else if (is_test)
                    begin
                        if (hs_state_reg == rlpc_pkg::ST_TESTING && role_rx_reg)
                        begin
                            hs_state_next = rlpc_pkg::ST_NORMAL;
                        end
                    end
                    else
                    begin
                        tick_count_next = 8'd0;
                    end
                end
            end
            rlpc_pkg::FUNC_POLL:
            begin
                priority if (linked_reg)
                begin
                    if (tx_status_reg != rlpc_pkg::TX_PENDING)
                    begin
                        tick_count_next = 8'd0;
                    end
                    expired_next = 1'b0;
                end
                else if (hs_state_reg == rlpc_pkg::ST_PAIRING)
                begin
                    priority if (expired_reg)
                    begin
                        // A pending send as transmitter holds off the role swap.
                        if (!(tx_status_reg == rlpc_pkg::TX_PENDING && !role_rx_reg))
                        begin
                            expired_next    = 1'b0;
                            draw_en         = 1'b1;
                            rand_seed_next  = rand_seed_reg ^ rand_word;
                            tick_limit_next = {1'b0, rand_word[7:1]};
                            tick_count_next = 8'd0;
                            role_rx_next    = !role_rx_reg;
                            tx_status_next  = rlpc_pkg::TX_UNKNOWN;
                        end
                    end
                    else if (!role_rx_reg)
                    begin
                        priority if (tx_status_reg == rlpc_pkg::TX_OK)
                        begin
                            tx_status_next = rlpc_pkg::TX_UNKNOWN;
                            hs_state_next  = rlpc_pkg::ST_CONFIG;
                        end
                        else if (tx_status_reg != rlpc_pkg::TX_PENDING)
                        begin
                            tx_status_next = rlpc_pkg::TX_PENDING;
                        end
                        else
                        begin
                        end
                    end
                    else
                    begin
                    end
                end
                else if (hs_state_reg == rlpc_pkg::ST_CONFIG ||
                         hs_state_reg == rlpc_pkg::ST_TESTING)
                begin
                    priority if (expired_reg)
                    begin
                        expired_next     = 1'b0;
                        cur_channel_next = 7'd0;
                        hs_state_next    = rlpc_pkg::ST_PAIRING;
                    end
                    else if (!role_rx_reg)
                    begin
                        priority if (tx_status_reg == rlpc_pkg::TX_OK)
                        begin
                            hs_state_next = (hs_state_reg == rlpc_pkg::ST_CONFIG) ?
                                            rlpc_pkg::ST_TESTING : rlpc_pkg::ST_NORMAL;
                            tx_status_next = rlpc_pkg::TX_UNKNOWN;
                        end
                        else if (tx_status_reg != rlpc_pkg::TX_PENDING)
                        begin
                            if (hs_state_reg == rlpc_pkg::ST_CONFIG)
                            begin
                                cur_channel_next = work_channel_reg;
                            end
                            tx_status_next = rlpc_pkg::TX_PENDING;
                        end
                        else
                        begin
                        end
                    end
                    else
                    begin
                    end
                end
                else
                begin
                    // Normal state: the first poll marks the link paired.
                    linked_next     = 1'b1;
                    tick_limit_next = link_ticks_reg;
                    tick_count_next = 8'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Commands, retune requests and deliveries caused by the item.
    always_comb
    begin
        send_valid_c    = 1'b0;
        send_code_c     = 8'd0;
        retune_c        = 1'b0;
        deliver_valid_c = 1'b0;

        unique case (func_code)
            rlpc_pkg::FUNC_RX_PACKET:
            begin
                if (rx_live)
                begin
                    if (is_conf && hs_state_reg == rlpc_pkg::ST_CONFIG && role_rx_reg)
                    begin
                        retune_c = 1'b1;
                    end
                    if (!is_nop && !is_conf && !is_test)
                    begin
                        deliver_valid_c = 1'b1;
                    end
                end
            end
            rlpc_pkg::FUNC_POLL:
            begin
                if (!linked_reg)
                begin
                    priority if (hs_state_reg == rlpc_pkg::ST_PAIRING)
                    begin
                        priority if (expired_reg)
                        begin
                            retune_c = !(tx_status_reg == rlpc_pkg::TX_PENDING && !role_rx_reg);
                        end
                        else if (!role_rx_reg && tx_status_reg != rlpc_pkg::TX_OK &&
                                 tx_status_reg != rlpc_pkg::TX_PENDING)
                        begin
                            send_valid_c = 1'b1;
                            send_code_c  = nop_code_reg;
                        end
                        else
                        begin
                        end
                    end
                    else if (hs_state_reg == rlpc_pkg::ST_CONFIG ||
                             hs_state_reg == rlpc_pkg::ST_TESTING)
                    begin
                        priority if (expired_reg)
                        begin
                            retune_c = 1'b1;
                        end
                        else if (!role_rx_reg)
                        begin
                            priority if (tx_status_reg == rlpc_pkg::TX_OK)
                            begin
                                retune_c = (hs_state_reg == rlpc_pkg::ST_CONFIG);
                            end
                            else if (tx_status_reg != rlpc_pkg::TX_PENDING)
                            begin
                                send_valid_c = 1'b1;
                                send_code_c  = (hs_state_reg == rlpc_pkg::ST_CONFIG) ?
                                               conf_code_reg : test_code_reg;
                            end
                            else
                            begin
                            end
                        end
                        else
                        begin
                        end
                    end
                    else
                    begin
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Assemble the result item from the updated state.
    always_comb
    begin
        result.link_state    = hs_state_next;
        result.rx_mode       = role_rx_next;
        result.send_valid    = send_valid_c;
        result.send_code     = send_code_c;
        result.retune        = retune_c;
        result.channel       = cur_channel_next;
        result.deliver_valid = deliver_valid_c;
        result.deliver_cmd   = deliver_valid_c ? rx_cmd : 8'd0;
        result.deliver_len   = !deliver_valid_c ? 5'd0 :
                               (len_m1[5] ? 5'd31 : len_m1[4:0]);
        result.paired        = linked_next;
    end

    // State registers, updated on each accepted input transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_state_reg    <= rlpc_pkg::ST_PAIRING;
            tx_status_reg   <= rlpc_pkg::TX_UNKNOWN;
            role_rx_reg     <= 1'b0;
            linked_reg      <= 1'b0;
            tick_count_reg  <= 8'd0;
            tick_limit_reg  <= rlpc_pkg::TICK_LIMIT_RST;
            expired_reg     <= 1'b0;
            cur_channel_reg <= 7'd0;
            rand_seed_reg   <= rlpc_pkg::RAND_SEED_RST;
            for (int i = 0; i < rlpc_pkg::RAND_DEPTH; i++)
            begin
                rand_table_reg[i] <= rlpc_pkg::RAND_TABLE_RST[i];
            end
        end
        else if (push)
        begin
            hs_state_reg    <= hs_state_next;
            tx_status_reg   <= tx_status_next;
            role_rx_reg     <= role_rx_next;
            linked_reg      <= linked_next;
            tick_count_reg  <= tick_count_next;
            tick_limit_reg  <= tick_limit_next;
            expired_reg     <= expired_next;
            cur_channel_reg <= cur_channel_next;
            rand_seed_reg   <= rand_seed_next;
            if (draw_en)
            begin
                rand_table_reg[rand_k] <= rand_word;
            end
        end
    end

    // Result buffer control: head feeds the port, skid catches a stalled push.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (head_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                head_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                head_reg <= result;
            end
        end
        else
        begin
        end
    end

    // Result ports.
    assign out_valid     = head_valid_reg;
    assign link_state    = head_reg.link_state;
    assign rx_mode       = head_reg.rx_mode;
    assign send_valid    = head_reg.send_valid;
    assign send_code     = head_reg.send_code;
    assign retune        = head_reg.retune;
    assign channel       = head_reg.channel;
    assign deliver_valid = head_reg.deliver_valid;
    assign deliver_cmd   = head_reg.deliver_cmd;
    assign deliver_len   = head_reg.deliver_len;
    assign paired        = head_reg.paired;

    // The skid entry is only ever filled behind an occupied head.
    `RLPC_ASSERT_NOW(a_skid_behind_head, skid_valid_reg, head_valid_reg)
    // A waiting skid entry stays until the head is taken.
    `RLPC_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !out_ready, skid_valid_reg)
    // Once paired, the link stays paired.
    `RLPC_ASSERT_NEXT(a_linked_sticky, linked_reg, linked_reg)
    // A delivery never comes with a send or a retune.
    `RLPC_ASSERT_NOW(a_deliver_alone, head_valid_reg && head_reg.deliver_valid,
        !head_reg.send_valid && !head_reg.retune)
    // Commands are only sent before the link reaches normal state.
    `RLPC_ASSERT_NOW(a_send_unpaired, head_valid_reg && head_reg.send_valid,
        head_reg.link_state != rlpc_pkg::ST_NORMAL && !head_reg.paired)

endmodule
